FILE: src/sfs_pkg.sv
package sfs_pkg;

  // default depth of the frame table
  localparam int SFS_MAX_FRAMES = 16;

  // item kinds
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_WRITE   = 3'd1;
  localparam logic [2:0] KIND_PAUSE   = 3'd2;
  localparam logic [2:0] KIND_RESUME  = 3'd3;
  localparam logic [2:0] KIND_RESTART = 3'd4;
  localparam logic [2:0] KIND_JUMP    = 3'd5;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_COUNT   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_PRESENT = 2'd2;
  localparam int CFG_DATA_W = 16;

  localparam int S_TDATA_W = 104;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 72;

  localparam logic [32:0] ELAPSED_MAX    = {33{1'b1}};
  localparam logic [15:0] REPEAT_ENDLESS = 16'hFFFF;

  typedef struct packed {
    logic        [2:0]  kind;
    logic        [3:0]  frame_index;
    logic        [31:0] frame_delay;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic        [15:0] rect_w;
    logic        [15:0] rect_h;
  } sfs_item_t;

  // table write request
  typedef struct packed {
    logic        en;
    logic [3:0]  idx;
    logic [31:0] delay;
    logic [63:0] rect;
  } sfs_wr_t;

  typedef struct packed {
    logic paused;
    logic done;
    logic advanced;
  } sfs_flags_t;

endpackage

FILE: src/sfs_frame_table.sv
module sfs_frame_table #(
  parameter int MAX_FRAMES = 16,
  parameter int FW = 4
) (
  input  logic             clk,
  input  sfs_pkg::sfs_wr_t wr,
  input  logic [FW-1:0]    delay_addr,
  input  logic [FW-1:0]    rect_addr,
  output logic [31:0]      delay_rd,
  output logic [63:0]      rect_rd
);
  import sfs_pkg::*;

  logic [31:0]   delay_mem [MAX_FRAMES];
  logic [63:0]   rect_mem  [MAX_FRAMES];
  logic [FW+3:0] wr_ext;
  logic [FW-1:0] wr_addr;

  assign wr_ext  = {{FW{1'b0}}, wr.idx};
  assign wr_addr = wr_ext[FW-1:0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      delay_mem[wr_addr] <= wr.delay;
      rect_mem[wr_addr]  <= wr.rect;
    end
  end

  assign delay_rd = delay_mem[delay_addr];
  // the result shows an entry written by the same transaction
  assign rect_rd  = (wr.en && (wr_addr == rect_addr)) ? wr.rect : rect_mem[rect_addr];

endmodule

FILE: src/sfs_state.sv
module sfs_state #(
  parameter int MAX_FRAMES = 16,
  parameter int FW = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_en,
  input  sfs_pkg::sfs_item_t item,
  input  logic [4:0]         frame_count,
  input  logic               source_present,
  input  logic               repeat_load,
  input  logic [15:0]        repeat_value,
  input  logic [31:0]        delay_rd,
  output logic [FW-1:0]      frame_cur,
  output logic [FW-1:0]      frame_next,
  output sfs_pkg::sfs_wr_t   wr,
  output sfs_pkg::sfs_flags_t flags
);
  import sfs_pkg::*;

  localparam int CW = FW + 5;

  logic [FW-1:0] frame_now;
  logic [32:0]   elapsed, elapsed_next;
  logic [15:0]   repeats_left, repeats_left_next;
  logic          paused, paused_next;
  logic          done, done_next;
  logic          adv;

  logic [CW-1:0] n;
  logic [CW-1:0] idx_ext;
  logic [CW-1:0] step_ext;
  logic [FW+3:0] jump_ext;
  logic          idx_ok;

  assign n        = (CW'(frame_count) > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(frame_count);
  assign idx_ext  = CW'(item.frame_index);
  assign idx_ok   = idx_ext < n;
  assign step_ext = CW'(frame_now) + CW'(1);
  assign jump_ext = {{FW{1'b0}}, item.frame_index};

  always_comb begin
    frame_next        = frame_now;
    elapsed_next      = elapsed;
    repeats_left_next = repeats_left;
    paused_next       = paused;
    done_next         = done;
    adv               = 1'b0;
    case (item.kind)
      KIND_TICK: begin
        if (source_present) begin
          if (elapsed != ELAPSED_MAX) begin
            elapsed_next = elapsed + 33'd1;
          end
          // delay below the incremented count is delay not above the old one
          if (!paused && !done && (n != '0) && ({1'b0, delay_rd} <= elapsed)) begin
            adv          = 1'b1;
            elapsed_next = '0;
            if (step_ext >= n) begin
              frame_next = '0;
              if (repeats_left != REPEAT_ENDLESS) begin
                if (repeats_left == '0) begin
                  done_next   = 1'b1;
                  paused_next = 1'b1;
                end else begin
                  repeats_left_next = repeats_left - 16'd1;
                end
              end
            end else begin
              frame_next = step_ext[FW-1:0];
            end
          end
        end
      end
      KIND_PAUSE: begin
        paused_next = 1'b1;
      end
      KIND_RESUME: begin
        paused_next  = 1'b0;
        elapsed_next = '0;
      end
      KIND_RESTART: begin
        frame_next   = '0;
        done_next    = 1'b0;
        paused_next  = 1'b0;
        elapsed_next = '0;
      end
      KIND_JUMP: begin
        if (idx_ok) begin
          frame_next   = jump_ext[FW-1:0];
          elapsed_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_now    <= '0;
      elapsed      <= '0;
      repeats_left <= '0;
      paused       <= 1'b0;
      done         <= 1'b0;
    end else begin
      if (repeat_load) begin
        repeats_left <= repeat_value;
      end else if (step_en) begin
        repeats_left <= repeats_left_next;
      end
      if (step_en) begin
        frame_now <= frame_next;
        elapsed   <= elapsed_next;
        paused    <= paused_next;
        done      <= done_next;
      end
    end
  end

  assign frame_cur      = frame_now;
  assign wr.en          = step_en && (item.kind == KIND_WRITE) && idx_ok;
  assign wr.idx         = item.frame_index;
  assign wr.delay       = item.frame_delay;
  assign wr.rect        = {item.rect_h, item.rect_w, item.rect_y, item.rect_x};
  assign flags.paused   = paused_next;
  assign flags.done     = done_next;
  assign flags.advanced = adv;

  a_adv_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    adv |-> (item.kind == KIND_TICK) && source_present)
    else $error("frame advanced without a tick and a source");

  a_frame_in_table: assert property (@(posedge clk) disable iff (rst)
    CW'(frame_now) < CW'(MAX_FRAMES))
    else $error("current frame outside the table");

  a_adv_clears_elapsed: assert property (@(posedge clk) disable iff (rst)
    step_en && adv |=> elapsed == '0)
    else $error("elapsed count not cleared after an advance");

endmodule

FILE: src/sprite_frame_sequencer.sv
// channel | direction | handshake         | payload
// s       | in        | s_tvalid/s_tready | s_tdata item fields, s_tuser kind
// m       | out       | m_tvalid/m_tready | m_tdata frame, rectangle and flags
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one transaction per clock when m is not stalled; a result is offered once its input
// transaction has passed the input register, then the result register.
// the state update for an item is combinational, between the two registers.
// rst is synchronous; it clears frame, counters, flags and configuration,
// the frame table is not cleared and reads back whatever was written.
// a stalled m holds its result; s keeps accepting until the input register fills.
module sprite_frame_sequencer #(
  parameter int MAX_FRAMES = sfs_pkg::SFS_MAX_FRAMES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // frame_index, frame_delay, rect_x, rect_y, rect_w, rect_h, zero fill
  input  logic [sfs_pkg::S_TDATA_W-1:0]      s_tdata,
  // kind
  input  logic [sfs_pkg::S_TUSER_W-1:0]      s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // current_frame, out_x, out_y, out_w, out_h, is_paused, is_done, advanced, zero fill
  output logic [sfs_pkg::M_TDATA_W-1:0]      m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sfs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sfs_pkg::*;

  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  logic          in_full;
  sfs_item_t     in_item;
  logic          fire;
  logic          s_fire;

  logic [4:0]    frame_count;
  logic          source_present;
  logic          cfg_fire;
  logic          repeat_load;

  logic [FW-1:0] frame_cur;
  logic [FW-1:0] frame_next;
  sfs_wr_t       wr;
  sfs_flags_t    flags;
  logic [31:0]   delay_rd;
  logic [63:0]   rect_rd;
  logic [FW+3:0] frame_ext;

  assign fire     = in_full && (!m_tvalid || m_tready);
  assign s_tready = !in_full || fire;
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_fire) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_item.kind        <= s_tuser;
      in_item.frame_index <= s_tdata[3:0];
      in_item.frame_delay <= s_tdata[35:4];
      in_item.rect_x      <= s_tdata[51:36];
      in_item.rect_y      <= s_tdata[67:52];
      in_item.rect_w      <= s_tdata[83:68];
      in_item.rect_h      <= s_tdata[99:84];
    end
  end

  // configuration registers
  assign cfg_ready   = 1'b1;
  assign cfg_fire    = cfg_valid && cfg_ready;
  assign repeat_load = cfg_fire && (cfg_index == CFG_REPEAT_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count    <= '0;
      source_present <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_FRAME_COUNT:    frame_count    <= cfg_data[4:0];
        CFG_SOURCE_PRESENT: source_present <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  sfs_state #(
    .MAX_FRAMES (MAX_FRAMES),
    .FW         (FW)
  ) u_state (
    .clk            (clk),
    .rst            (rst),
    .step_en        (fire),
    .item           (in_item),
    .frame_count    (frame_count),
    .source_present (source_present),
    .repeat_load    (repeat_load),
    .repeat_value   (cfg_data),
    .delay_rd       (delay_rd),
    .frame_cur      (frame_cur),
    .frame_next     (frame_next),
    .wr             (wr),
    .flags          (flags)
  );

  sfs_frame_table #(
    .MAX_FRAMES (MAX_FRAMES),
    .FW         (FW)
  ) u_table (
    .clk        (clk),
    .wr         (wr),
    .delay_addr (frame_cur),
    .rect_addr  (frame_next),
    .delay_rd   (delay_rd),
    .rect_rd    (rect_rd)
  );

  assign frame_ext = {4'b0000, frame_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {1'b0, flags.advanced, flags.done, flags.paused, rect_rd, frame_ext[3:0]};
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_full && m_tvalid && !m_tready)
    else $error("input refused while the pipeline can move");

endmodule
